>>> hdl/text_stream_cat_filter_unit_assert.svh
// Assertion macros shared by the text stream cat filter RTL.
// No dependencies; taken in by `include from the modules that check themselves.
`ifndef TEXT_STREAM_CAT_FILTER_UNIT_ASSERT_SVH
`define TEXT_STREAM_CAT_FILTER_UNIT_ASSERT_SVH

// pre holds -> post holds in the same cycle
`define TSCF_ASSERT_SAME(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// pre holds -> post holds in the next cycle
`define TSCF_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hdl/tscf_pkg.sv
// Package for the text stream cat filter: constants, register indexes, word types.
// No dependencies.
`default_nettype none

package tscf_pkg;

  localparam int NUMBER_DIGITS = 6;
  localparam int BCD_W         = 4 * NUMBER_DIGITS;
  localparam int CHAR_MAX      = 4;
  localparam int CHAR_IDX_W    = 2;
  localparam int LEN_W         = 3;
  localparam int DIG_IDX_W     = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
  localparam int POS_RAW_W     = $clog2(NUMBER_DIGITS + 1);
  localparam int POS_W         = (POS_RAW_W > CHAR_IDX_W) ? POS_RAW_W : CHAR_IDX_W + 1;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = 2;
  localparam int QCNT_W        = 3;

  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_MODE      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SQUEEZE_BLANK    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_TABS        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_ENDS        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_NONPRINTING = 3'd4;

  localparam logic [1:0] NUM_NONE     = 2'd0;
  localparam logic [1:0] NUM_ALL      = 2'd1;
  localparam logic [1:0] NUM_NONBLANK = 2'd2;

  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_DASH   = 8'd45;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_QMARK  = 8'd63;
  localparam logic [7:0] CH_AT     = 8'd64;
  localparam logic [7:0] CH_I      = 8'd73;
  localparam logic [7:0] CH_M      = 8'd77;
  localparam logic [7:0] CH_CARET  = 8'd94;
  localparam logic [7:0] CH_DEL    = 8'd127;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       file_start;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [1:0] number_mode;
    logic       squeeze_blank;
    logic       show_tabs;
    logic       show_ends;
    logic       show_nonprinting;
  } cfg_t;

  // one classified input byte: optional line number, then 1..4 characters
  typedef struct packed {
    logic                               num;
    logic [NUMBER_DIGITS-1:0][7:0]      digits;
    logic [CHAR_MAX-1:0][7:0]           chars;
    logic [LEN_W-1:0]                   len;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

>>> hdl/tscf_front.sv
// Front end: accepts input words, keeps line state, classifies each byte into a descriptor.
// Depends on tscf_pkg and text_stream_cat_filter_unit_assert.svh.
`default_nettype none
`include "text_stream_cat_filter_unit_assert.svh"

module tscf_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire tscf_pkg::cfg_t   cfg,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire tscf_pkg::in_word_t in_word,
  input  wire tscf_pkg::q_status_t q_status,
  output logic                  q_push,
  output tscf_pkg::desc_t       q_desc
);
  import tscf_pkg::*;

  logic [7:0]       previous_byte;
  logic [BCD_W-1:0] line_number_bcd;
  logic [1:0]       blank_run;

  logic [7:0]       prev_eff;
  logic [BCD_W-1:0] bcd_eff;
  logic [1:0]       run_eff;
  logic [1:0]       blank_run_next;
  logic [BCD_W-1:0] line_number_bcd_next;
  logic [BCD_W-1:0] bcd_inc;
  logic             squeeze_hit;
  logic             drop;
  logic             num_emit;
  logic             accept;
  logic [7:0]       c;
  logic [7:0]       low;

  logic [NUMBER_DIGITS-1:0][7:0] num_digits;
  logic [CHAR_MAX-1:0][7:0]      exp_chars;
  logic [LEN_W-1:0]              exp_len;

  assign c        = in_word.in_byte;
  assign low      = {1'b0, c[6:0]};
  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  assign prev_eff = in_word.file_start ? CH_NL : previous_byte;
  assign bcd_eff  = in_word.file_start ? BCD_W'(1) : line_number_bcd;
  assign run_eff  = in_word.file_start ? 2'd0 : blank_run;

  assign squeeze_hit = cfg.squeeze_blank && (c == CH_NL) && (prev_eff == CH_NL);
  assign blank_run_next = squeeze_hit ? ((run_eff == 2'd2) ? 2'd2 : run_eff + 2'd1) : 2'd0;
  assign drop = squeeze_hit && (blank_run_next == 2'd2);
  assign num_emit = !drop && (prev_eff == CH_NL) &&
                    ((cfg.number_mode == NUM_ALL) ||
                     ((cfg.number_mode == NUM_NONBLANK) && (c != CH_NL)));

  // saturating BCD increment
  always_comb begin
    logic       carry;
    logic [3:0] d;
    carry   = 1'b1;
    bcd_inc = '0;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      d = bcd_eff[4*i +: 4];
      if (carry) begin
        if (d == 4'd9) begin
          d = 4'd0;
        end else begin
          d     = d + 4'd1;
          carry = 1'b0;
        end
      end
      bcd_inc[4*i +: 4] = d;
    end
    if (carry) begin
      bcd_inc = bcd_eff;
    end
  end

  assign line_number_bcd_next = num_emit ? bcd_inc : bcd_eff;

  // line number digits, leading zeros as spaces
  always_comb begin
    logic       started;
    logic [3:0] d;
    started = 1'b0;
    num_digits = '0;
    for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
      d = bcd_eff[4*i +: 4];
      if (d != 4'd0 || i == 0) begin
        started = 1'b1;
      end
      num_digits[NUMBER_DIGITS-1-i] = started ? (CH_ZERO + {4'd0, d}) : CH_SPACE;
    end
  end

  // character expansion
  always_comb begin
    exp_chars = '0;
    exp_len   = LEN_W'(1);
    exp_chars[0] = c;
    if (c == CH_TAB && cfg.show_tabs) begin
      exp_chars[0] = CH_CARET;
      exp_chars[1] = CH_I;
      exp_len      = LEN_W'(2);
    end else if (c == CH_NL) begin
      if (cfg.show_ends) begin
        exp_chars[0] = CH_DOLLAR;
        exp_chars[1] = CH_NL;
        exp_len      = LEN_W'(2);
      end
    end else if (cfg.show_nonprinting && c != CH_TAB) begin
      if (c < CH_SPACE) begin
        exp_chars[0] = CH_CARET;
        exp_chars[1] = c + CH_AT;
        exp_len      = LEN_W'(2);
      end else if (c == CH_DEL) begin
        exp_chars[0] = CH_CARET;
        exp_chars[1] = CH_QMARK;
        exp_len      = LEN_W'(2);
      end else if (c[7]) begin
        exp_chars[0] = CH_M;
        exp_chars[1] = CH_DASH;
        if (low < CH_SPACE) begin
          exp_chars[2] = CH_CARET;
          exp_chars[3] = low + CH_AT;
          exp_len      = LEN_W'(4);
        end else if (low == CH_DEL) begin
          exp_chars[2] = CH_CARET;
          exp_chars[3] = CH_QMARK;
          exp_len      = LEN_W'(4);
        end else begin
          exp_chars[2] = low;
          exp_len      = LEN_W'(3);
        end
      end
    end
  end

  assign q_desc = '{num: num_emit, digits: num_digits, chars: exp_chars, len: exp_len};
  assign q_push = accept && !drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_byte   <= CH_NL;
      line_number_bcd <= BCD_W'(1);
      blank_run       <= 2'd0;
    end else if (accept) begin
      previous_byte   <= c;
      line_number_bcd <= line_number_bcd_next;
      blank_run       <= blank_run_next;
    end
  end

  `TSCF_ASSERT_NEXT(a_drop_saturates, clk, rst, accept && !q_push, blank_run == 2'd2,
                    "dropped word did not leave blank run saturated")

endmodule

`default_nettype wire

>>> hdl/tscf_queue.sv
// Descriptor queue between front and back end, a few entries of registers.
// Depends on tscf_pkg and text_stream_cat_filter_unit_assert.svh.
`default_nettype none
`include "text_stream_cat_filter_unit_assert.svh"

module tscf_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire tscf_pkg::desc_t push_desc,
  input  wire logic            pop,
  output tscf_pkg::desc_t      head,
  output tscf_pkg::q_status_t  status
);
  import tscf_pkg::*;

  desc_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head         = entries[rd_ptr];
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  `TSCF_ASSERT_SAME(a_no_overflow, clk, rst, push, !status.full, "push into full queue")
  `TSCF_ASSERT_SAME(a_no_underflow, clk, rst, pop, !status.empty, "pop from empty queue")
  `TSCF_ASSERT_SAME(a_count_range, clk, rst, 1'b1, count <= QCNT_W'(QUEUE_DEPTH),
                    "queue count out of range")

endmodule

`default_nettype wire

>>> hdl/tscf_back.sv
// Back end: walks each descriptor one output byte per cycle into the output register, unless stalled.
// Depends on tscf_pkg and text_stream_cat_filter_unit_assert.svh.
`default_nettype none
`include "text_stream_cat_filter_unit_assert.svh"

module tscf_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tscf_pkg::desc_t     q_head,
  input  wire tscf_pkg::q_status_t q_status,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tscf_pkg::out_word_t      out_word
);
  import tscf_pkg::*;

  logic [POS_W-1:0] pos;
  logic             phase_char;
  logic             char_phase;
  logic             emit;
  logic             last_byte;
  logic             num_done;
  logic [7:0]       sel_byte;

  assign char_phase = phase_char || !q_head.num;
  assign emit       = !q_status.empty && (!out_valid || out_ready);
  assign num_done   = (pos == POS_W'(NUMBER_DIGITS));
  assign last_byte  = char_phase && (pos == POS_W'(q_head.len) - POS_W'(1));
  assign q_pop      = emit && last_byte;

  always_comb begin
    if (char_phase) begin
      sel_byte = q_head.chars[pos[CHAR_IDX_W-1:0]];
    end else if (num_done) begin
      sel_byte = CH_TAB;
    end else begin
      sel_byte = q_head.digits[pos[DIG_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pos        <= '0;
      phase_char <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
      if (last_byte) begin
        pos        <= '0;
        phase_char <= 1'b0;
      end else if (!char_phase && num_done) begin
        pos        <= '0;
        phase_char <= 1'b1;
      end else begin
        pos <= pos + POS_W'(1);
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word.out_byte    <= sel_byte;
      out_word.last_of_run <= last_byte;
    end
  end

  `TSCF_ASSERT_NEXT(a_pop_rewinds, clk, rst, q_pop, pos == '0 && !phase_char,
                    "walk position not rewound after pop")

endmodule

`default_nettype wire

>>> hdl/text_stream_cat_filter_unit.sv
// Usage:
// Input channel in_valid/in_ready/in_word carries one text byte per word, with
// file_start marking the first byte of a new file (clears line count, blank run
// and previous byte). Output channel out_valid/out_ready/out_word carries one
// rendered character per word; last_of_run flags the final character of a byte.
// Options are written through cfg_we/cfg_index/cfg_data while the block is idle.
// The first output word of an input byte passes the queue, then the output
// register. The back end sends one output word per cycle while the receiver is
// ready; a byte expands to 1 to 11 characters, and a squeezed empty line gives
// no output. The front end takes a byte every cycle while the four-entry
// descriptor queue has room, so plain text streams at one byte per cycle to a
// ready receiver. When the receiver stalls, the output register holds its word,
// the queue fills, and in_ready drops. Reset clears options, line state, queue
// and output. Depends on tscf_pkg, tscf_front, tscf_queue, tscf_back.
`default_nettype none

module text_stream_cat_filter_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire tscf_pkg::in_word_t               in_word,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output tscf_pkg::out_word_t                   out_word,
  input  wire logic                             cfg_we,
  input  wire logic [tscf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tscf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tscf_pkg::*;

  cfg_t      cfg;
  desc_t     push_desc;
  desc_t     head;
  q_status_t q_status;
  logic      q_push;
  logic      q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUMBER_MODE:      cfg.number_mode      <= cfg_data;
        REG_SQUEEZE_BLANK:    cfg.squeeze_blank    <= cfg_data[0];
        REG_SHOW_TABS:        cfg.show_tabs        <= cfg_data[0];
        REG_SHOW_ENDS:        cfg.show_ends        <= cfg_data[0];
        REG_SHOW_NONPRINTING: cfg.show_nonprinting <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  tscf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .q_status (q_status),
    .q_push   (q_push),
    .q_desc   (push_desc)
  );

  tscf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .head      (head),
    .status    (q_status)
  );

  tscf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_head    (head),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

>>> verif/text_stream_cat_filter_unit_tb.sv
// Self-checking testbench for text_stream_cat_filter_unit: directed and random text bytes
// under several option settings and handshake pressure, each output word checked in order.
// Depends on tscf_pkg and the text_stream_cat_filter_unit RTL.
module text_stream_cat_filter_unit_tb;
  import tscf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  text_stream_cat_filter_unit u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  in_word_t byte_feed[$];
  out_word_t expected_chars[$];

  cfg_t opts = '0;
  logic [7:0] prev_char = CH_NL;
  logic [BCD_W-1:0] line_bcd = BCD_W'(1);
  logic [1:0] blank_count = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;
  int mismatch_count = 0;
  logic hold_go = 1'b0;
  logic hold_used = 1'b0;
  int hold_left = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("text_stream_cat_filter_unit_tb NOT OK");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want_v);
    $display("[cycle %0d] %s: got %h want %h", cycle_count, what, got, want_v);
    mismatch_count++;
  endtask

  // expected character sequence for one accepted byte
  function automatic void render_byte(in_word_t w);
    logic [7:0] c;
    logic [7:0] low;
    logic [7:0] text[$];
    logic started;
    int digit;
    int carry;
    logic [BCD_W-1:0] bumped;
    out_word_t ow;
    c = w.in_byte;
    if (w.file_start) begin
      line_bcd = BCD_W'(1);
      blank_count = '0;
      prev_char = CH_NL;
    end
    if (opts.squeeze_blank && c == CH_NL && prev_char == CH_NL) begin
      if (blank_count < 2) blank_count = blank_count + 2'd1;
      if (blank_count > 1) return;
    end else begin
      blank_count = '0;
    end
    if (prev_char == CH_NL && (opts.number_mode == NUM_ALL ||
        (opts.number_mode == NUM_NONBLANK && c != CH_NL))) begin
      started = 1'b0;
      for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
        digit = int'(line_bcd[4*i +: 4]);
        if (digit != 0 || i == 0) started = 1'b1;
        text.push_back(started ? CH_ZERO + 8'(digit) : CH_SPACE);
      end
      text.push_back(CH_TAB);
      carry = 1;
      bumped = '0;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
        digit = int'(line_bcd[4*i +: 4]) + carry;
        if (digit > 9) begin
          digit = 0;
          carry = 1;
        end else begin
          carry = 0;
        end
        bumped[4*i +: 4] = 4'(digit);
      end
      if (carry == 0) line_bcd = bumped;
    end
    if (c == CH_TAB && opts.show_tabs) begin
      text.push_back(CH_CARET);
      text.push_back(CH_I);
    end else if (c == CH_NL) begin
      if (opts.show_ends) text.push_back(CH_DOLLAR);
      text.push_back(c);
    end else if (opts.show_nonprinting && c != CH_TAB) begin
      if (c < CH_SPACE) begin
        text.push_back(CH_CARET);
        text.push_back(c + CH_AT);
      end else if (c == CH_DEL) begin
        text.push_back(CH_CARET);
        text.push_back(CH_QMARK);
      end else if (c[7]) begin
        low = {1'b0, c[6:0]};
        text.push_back(CH_M);
        text.push_back(CH_DASH);
        if (low < CH_SPACE) begin
          text.push_back(CH_CARET);
          text.push_back(low + CH_AT);
        end else if (low == CH_DEL) begin
          text.push_back(CH_CARET);
          text.push_back(CH_QMARK);
        end else begin
          text.push_back(low);
        end
      end else begin
        text.push_back(c);
      end
    end else begin
      text.push_back(c);
    end
    prev_char = c;
    foreach (text[k]) begin
      ow.out_byte = text[k];
      ow.last_of_run = (k == text.size() - 1);
      expected_chars.push_back(ow);
    end
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_word <= byte_feed.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) render_byte(in_word);
  end

  // receiver, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_out
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("output word with nothing expected", out_word.out_byte, 8'h00);
      end else begin
        want = expected_chars.pop_front();
        if (out_word.out_byte !== want.out_byte)
          report_mismatch("out_byte", out_word.out_byte, want.out_byte);
        if (out_word.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", 8'(out_word.last_of_run), 8'(want.last_of_run));
      end
    end
  end

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_NUMBER_MODE: opts.number_mode = data;
      REG_SQUEEZE_BLANK: opts.squeeze_blank = data[0];
      REG_SHOW_TABS: opts.show_tabs = data[0];
      REG_SHOW_ENDS: opts.show_ends = data[0];
      REG_SHOW_NONPRINTING: opts.show_nonprinting = data[0];
      default: ;
    endcase
  endtask

  // upper data bit of one-bit registers is random, to exercise masking
  task automatic set_options(logic [1:0] mode, logic sq, logic tabs, logic ends, logic np);
    write_reg(REG_NUMBER_MODE, mode);
    write_reg(REG_SQUEEZE_BLANK, {1'($urandom_range(1)), sq});
    write_reg(REG_SHOW_TABS, {1'($urandom_range(1)), tabs});
    write_reg(REG_SHOW_ENDS, {1'($urandom_range(1)), ends});
    write_reg(REG_SHOW_NONPRINTING, {1'($urandom_range(1)), np});
    write_reg(REG_SHOW_NONPRINTING + 3'(1 + $urandom_range(2)), 2'($urandom_range(3)));
  endtask

  task automatic feed(logic [7:0] b, logic fs);
    in_word_t w;
    w.in_byte = b;
    w.file_start = fs;
    byte_feed.push_back(w);
  endtask

  function automatic in_word_t random_word();
    in_word_t w;
    int roll;
    roll = $urandom_range(99);
    if (roll < 25) w.in_byte = CH_NL;
    else if (roll < 32) w.in_byte = CH_TAB;
    else if (roll < 60) w.in_byte = 8'($urandom_range(126, 32));
    else if (roll < 70) w.in_byte = 8'($urandom_range(31, 0));
    else if (roll < 74) w.in_byte = $urandom_range(1) ? CH_DEL : 8'hFF;
    else w.in_byte = 8'($urandom_range(254, 128));
    w.file_start = ($urandom_range(99) < 3);
    return w;
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (byte_feed.size() != 0 || in_valid || expected_chars.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_random(int n, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n) byte_feed.push_back(random_word());
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    set_options(NUM_ALL, 1'b1, 1'b1, 1'b1, 1'b1);
    feed(8'h80, 1'b0);
    feed("A", 1'b0);
    feed(CH_TAB, 1'b0);
    feed(8'h00, 1'b0);
    feed(8'h1F, 1'b0);
    feed(CH_DEL, 1'b0);
    feed(8'hFF, 1'b0);
    feed(8'h9F, 1'b0);
    feed(8'hA0, 1'b0);
    feed(8'hFE, 1'b0);
    feed(CH_SPACE, 1'b0);
    feed(CH_NL, 1'b0);
    feed(CH_NL, 1'b0);
    feed(CH_NL, 1'b0);
    feed(CH_NL, 1'b0);
    feed("z", 1'b0);
    feed(CH_NL, 1'b0);
    feed(CH_NL, 1'b1);
    feed(8'hC1, 1'b1);
    feed(CH_NL, 1'b0);
    wait_drained();

    set_options(NUM_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
    run_random(50, 0, 0);
    set_options(NUM_ALL, 1'b1, 1'b1, 1'b1, 1'b1);
    run_random(50, 81, 0);
    set_options(NUM_NONBLANK, 1'b1, 1'b0, 1'b1, 1'b1);
    run_random(50, 0, 81);
    set_options(2'd3, 1'b0, 1'b1, 1'b0, 1'b1);
    run_random(50, 27, 27);
    set_options(NUM_NONBLANK, 1'b0, 1'b1, 1'b1, 1'b0);
    hold_go = 1'b1;
    run_random(50, 0, 0);
    set_options(NUM_ALL, 1'b1, 1'b0, 1'b0, 1'b1);
    run_random(50, 27, 27);

    if (mismatch_count == 0) begin
      $display("text_stream_cat_filter_unit_tb OK");
    end else begin
      $display("text_stream_cat_filter_unit_tb NOT OK");
    end
    $finish;
  end
endmodule

>>> text_stream_cat_filter_unit.f
+incdir+hdl
hdl/tscf_pkg.sv
hdl/tscf_front.sv
hdl/tscf_queue.sv
hdl/tscf_back.sv
hdl/text_stream_cat_filter_unit.sv
verif/text_stream_cat_filter_unit_tb.sv
